>>> rtl/vebd_pkg.sv
// Shared types, constants and helpers for the event byte stream decoder.
`timescale 1ns / 1ps

package vebd_pkg;

	// Field widths of the byte stream and of a decoded event
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CoordW = 7;
	localparam int unsigned ModeW  = 2;
	localparam int unsigned StampW = 32;
	localparam int unsigned TimeW  = 64;
	// Delta carries one sign bit over stamp + limit, which stays below 2^33
	localparam int unsigned DeltaW = StampW + 2;

	// Events counted by one tick each before deltas are applied
	localparam logic [TimeW-1:0] WarmupTicks = TimeW'(8);

	// Timestamp modes
	localparam logic [ModeW-1:0] MODE_NONE = 2'd0;
	localparam logic [ModeW-1:0] MODE_TS16 = 2'd1;
	localparam logic [ModeW-1:0] MODE_TS24 = 2'd2;
	localparam logic [ModeW-1:0] MODE_TS32 = 2'd3;

	// Parsed event handed from the parser to the time accumulator
	typedef struct packed {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic              pol;
		logic              tick;   // mode carried a timestamp
		logic [DeltaW-1:0] delta;  // two's complement, sign-extend to use
	} vebd_evt_t;

	// Timestamp bytes needed by a mode
	function automatic logic [2:0] stamp_bytes(input logic [ModeW-1:0] mode);
		logic [2:0] n;
		case (mode)
			MODE_TS16: n = 3'd2;
			MODE_TS24: n = 3'd3;
			MODE_TS32: n = 3'd4;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	// Counter wrap limit of a mode
	function automatic logic [DeltaW-1:0] stamp_limit(input logic [ModeW-1:0] mode);
		logic [DeltaW-1:0] l;
		case (mode)
			MODE_TS16: l = DeltaW'(64'h1_0000);
			MODE_TS24: l = DeltaW'(64'h100_0000);
			MODE_TS32: l = DeltaW'(64'h1_0000_0000);
			default:   l = '0;
		endcase
		return l;
	endfunction

	// Mask a gathered stamp to the width of a mode
	function automatic logic [StampW-1:0] stamp_mask(input logic [ModeW-1:0] mode,
		input logic [StampW-1:0] raw);
		logic [StampW-1:0] s;
		case (mode)
			MODE_TS16: s = {16'h0, raw[15:0]};
			MODE_TS24: s = {8'h0, raw[23:0]};
			MODE_TS32: s = raw;
			default:   s = '0;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/vebd_if.sv
// Channel interfaces: raw byte input, decoded event output, mode write port.
`timescale 1ns / 1ps

interface vebd_byte_if;
	import vebd_pkg::*;
	logic              valid;
	logic              ready;
	logic [ByteW-1:0]  byte_in;
	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

interface vebd_event_if;
	import vebd_pkg::*;
	logic              valid;
	logic              ready;
	logic [CoordW-1:0] event_x;
	logic [CoordW-1:0] event_y;
	logic              polarity;
	logic [TimeW-1:0]  event_time;
	modport source (output valid, output event_x, output event_y, output polarity,
		output event_time, input ready);
	modport sink   (input valid, input event_x, input event_y, input polarity,
		input event_time, output ready);
endinterface

interface vebd_cfg_if;
	import vebd_pkg::*;
	logic              valid;
	logic              ready;
	logic [ModeW-1:0]  stamp_mode;
	modport source (output valid, output stamp_mode, input ready);
	modport sink   (input valid, input stamp_mode, output ready);
endinterface

>>> rtl/vebd_parse.sv
// Byte parser: frames events, gathers timestamps and forms the stamp delta.
`timescale 1ns / 1ps

module vebd_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [vebd_pkg::ModeW-1:0] mode,
	vebd_byte_if.sink                 byte_ch,
	output logic                      evt_valid_s1,
	output vebd_pkg::vebd_evt_t       evt_s1,
	input  logic                      evt_take
);
	import vebd_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'd0,
		PH_SECOND = 3'd1,
		PH_TS1    = 3'd2,
		PH_TS2    = 3'd3,
		PH_TS3    = 3'd4,
		PH_TS4    = 3'd5
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [CoordW-1:0]   row_q, row_d;
	logic [ByteW-1:0]    second_q, second_d;
	logic [StampW-1:0]   gather_q, gather_d;
	logic [StampW-1:0]   prev_q;
	logic [StampW-1:0]   gather_new;
	logic [StampW-1:0]   stamp;
	logic [2:0]          got;
	logic                fin;
	logic                accept;
	logic [ByteW-1:0]    b;
	logic [DeltaW-1:0]   d_dir;
	logic [DeltaW-1:0]   d_wrap;
	vebd_evt_t           evt_d;

	// Take a word unless a parsed event is stuck in stage one
	assign byte_ch.ready = !evt_valid_s1 || evt_take;
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign b             = byte_ch.byte_in;
	assign gather_new    = {gather_q[StampW-ByteW-1:0], b};

	// Advance the framing phase
	always_comb begin
		phase_d  = phase_q;
		row_d    = row_q;
		second_d = second_q;
		gather_d = gather_q;
		fin      = 1'b0;
		got      = 3'd0;
		case (phase_q)
			PH_FIRST: begin
				// drop bytes without the start mark
				if (b[ByteW-1]) begin
					row_d   = b[CoordW-1:0];
					phase_d = PH_SECOND;
				end
			end
			PH_SECOND: begin
				second_d = b;
				gather_d = '0;
				if (stamp_bytes(mode) == 3'd0) begin
					fin     = 1'b1;
					phase_d = PH_FIRST;
				end else begin
					phase_d = PH_TS1;
				end
			end
			default: begin
				gather_d = gather_new;
				case (phase_q)
					PH_TS1:  got = 3'd1;
					PH_TS2:  got = 3'd2;
					PH_TS3:  got = 3'd3;
					default: got = 3'd4;
				endcase
				if (got >= stamp_bytes(mode) || got == 3'd4) begin
					fin     = 1'b1;
					phase_d = PH_FIRST;
				end else begin
					case (phase_q)
						PH_TS1:  phase_d = PH_TS2;
						PH_TS2:  phase_d = PH_TS3;
						default: phase_d = PH_TS4;
					endcase
				end
			end
		endcase
	end

	// Form the stamp and its delta against the previous stamp
	always_comb begin
		stamp  = (phase_q == PH_SECOND) ? '0 : stamp_mask(mode, gather_new);
		d_dir  = {2'b00, stamp} - {2'b00, prev_q};
		d_wrap = {2'b00, stamp} + stamp_limit(mode) - {2'b00, prev_q};
		evt_d.x     = second_d[CoordW-1:0];
		evt_d.y     = row_q;
		evt_d.pol   = second_d[ByteW-1];
		evt_d.tick  = (mode != MODE_NONE);
		evt_d.delta = d_dir[DeltaW-1] ? d_wrap : d_dir;
	end

	// Hold parser state and the stage-one event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			row_q        <= '0;
			second_q     <= '0;
			gather_q     <= '0;
			prev_q       <= '0;
			evt_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q  <= phase_d;
				row_q    <= row_d;
				second_q <= second_d;
				gather_q <= gather_d;
				if (fin)
					prev_q <= stamp;
			end
			if (accept && fin)
				evt_valid_s1 <= 1'b1;
			else if (evt_take)
				evt_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fin)
			evt_s1 <= evt_d;
	end

endmodule

>>> rtl/vebd_time.sv
// Time accumulator and output register for decoded events.
`timescale 1ns / 1ps

module vebd_time (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid_s1,
	input  vebd_pkg::vebd_evt_t evt_s1,
	output logic                evt_take,
	vebd_event_if.source        event_ch
);
	import vebd_pkg::*;

	logic [TimeW-1:0] time_q;
	logic [TimeW-1:0] time_d;
	logic [TimeW-1:0] step;
	logic             out_valid_q;

	// Move the event on when the output register is free or being emptied
	assign evt_take       = evt_valid_s1 && (!out_valid_q || event_ch.ready);
	assign event_ch.valid = out_valid_q;

	// Add one tick during warm-up, the stamp delta after it
	always_comb begin
		if (time_q < WarmupTicks)
			step = TimeW'(1);
		else
			step = {{(TimeW-DeltaW){evt_s1.delta[DeltaW-1]}}, evt_s1.delta};
		time_d = evt_s1.tick ? time_q + step : time_q;
	end

	// Hold running time and the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt_take) begin
				time_q      <= time_d;
				out_valid_q <= 1'b1;
			end else if (event_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			event_ch.event_x    <= evt_s1.x;
			event_ch.event_y    <= evt_s1.y;
			event_ch.polarity   <= evt_s1.pol;
			event_ch.event_time <= time_d;
		end
	end

endmodule

>>> rtl/vision_event_byte_decoder.sv
// Top level of the event camera byte stream decoder.
//
//   channel   dir  width  contents
//   byte_ch   in   8      raw sensor byte
//   event_ch  out  79     x, y, polarity, 64-bit event time
//   cfg       in   2      timestamp mode write
//
// One byte is taken per cycle while byte_ch holds ready. An event passes from its
// last byte through the parser register, then the time accumulator, whose 64-bit
// add sets the path. arst_n clears parsing state, the running time and the mode.
// A stalled output holds the event; the parser register then fills and byte_ch
// drops ready. Mode writes are taken every cycle.
`timescale 1ns / 1ps

module vision_event_byte_decoder (
	input  logic          clk,
	input  logic          arst_n,
	vebd_byte_if.sink     byte_ch,
	vebd_event_if.source  event_ch,
	vebd_cfg_if.sink      cfg
);
	import vebd_pkg::*;

	logic [ModeW-1:0] mode_q;
	logic             evt_valid_s1;
	vebd_evt_t        evt_s1;
	logic             evt_take;

	assign cfg.ready = 1'b1;

	// Hold the timestamp mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_NONE;
		else if (cfg.valid)
			mode_q <= cfg.stamp_mode;
	end

	vebd_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.byte_ch      (byte_ch),
		.evt_valid_s1 (evt_valid_s1),
		.evt_s1       (evt_s1),
		.evt_take     (evt_take)
	);

	vebd_time u_time (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt_valid_s1 (evt_valid_s1),
		.evt_s1       (evt_s1),
		.evt_take     (evt_take),
		.event_ch     (event_ch)
	);

endmodule
